>>> hw/rtl/ddo_pkg.sv
// shared types, constants and helpers for the differential drive odometry core
// no dependencies; imported by the divider, the cordic unit, the top level and the testbench
`timescale 1ns / 1ps

package ddo_pkg;

    // divider geometry: widest dividend is the heading step (78 bits)
    localparam int unsigned DIV_W      = 80;
    localparam int unsigned DVS_W      = 24;
    localparam int unsigned DIV_CNT_W  = 7;

    // cordic geometry
    localparam int unsigned CORD_W     = 50;
    localparam int unsigned ANG_W      = 34;
    localparam int unsigned STEP_CNT_W = 6;
    localparam int unsigned CORDIC_STEPS_DEF = 24;

    // fixed-point constants
    localparam logic [31:0] KINV_Q32   = 32'd2608131496;
    localparam logic [31:0] RAD_TO_BIN = 32'd683565276;
    localparam logic [31:0] US_PER_S   = 32'd1000000;

    // register indexes
    localparam logic [1:0] CFG_MPC = 2'd0;
    localparam logic [1:0] CFG_APC = 2'd1;
    localparam logic [1:0] CFG_TW  = 2'd2;

    localparam logic [31:0] MPC_RESET = 32'd472256;
    localparam logic [31:0] APC_RESET = 32'd2698608;
    localparam logic [20:0] TW_RESET  = 21'd39322;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SPD_L0,
        ST_SPD_L1,
        ST_SPD_L2,
        ST_SPD_LW,
        ST_SPD_R0,
        ST_SPD_R1,
        ST_SPD_R2,
        ST_SPD_RW,
        ST_TURN,
        ST_TURN_W,
        ST_HEAD0,
        ST_HEAD1,
        ST_HEAD2,
        ST_HEAD3,
        ST_HEAD_W,
        ST_DIST0,
        ST_DIST1,
        ST_DIST2,
        ST_DIST3,
        ST_CORD_W,
        ST_ANG_L,
        ST_ANG_R,
        ST_ANG_FIN,
        ST_PUB
    } seq_state_t;

    // arctan of 2^-i as binary angle
    function automatic logic [31:0] atan_bin(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // signed 32-bit result from an unsigned quotient, clamped at the limits
    function automatic logic [31:0] sat_quot(input logic [DIV_W-1:0] q, input logic neg);
        logic big;
        big = |q[DIV_W-1:31];
        if (big) begin
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

endpackage

>>> hw/rtl/ddo_div.sv
// restoring divider, one quotient bit per cycle
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ddo_pkg::DIV_W-1:0] dividend,
    input  logic [ddo_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [ddo_pkg::DIV_W-1:0] quotient
);
    import ddo_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W:0]       rem_sh;
    logic [DVS_W+1:0]     diff;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, dvs_reg};
    assign ge     = ~diff[DVS_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/ddo_cordic.sv
// iterative cordic rotation, one micro-rotation per cycle
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int unsigned STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ddo_pkg::CORD_W-1:0] x_in,
    input  logic signed [ddo_pkg::ANG_W-1:0]  z_in,
    output logic                              done,
    output logic signed [ddo_pkg::CORD_W-1:0] x_out,
    output logic signed [ddo_pkg::CORD_W-1:0] y_out
);
    import ddo_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [CORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic signed [CORD_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]  at;
    logic [4:0]               idx;

    assign idx = cnt_reg[4:0];
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign at  = $signed({2'b00, atan_bin(idx)});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = x_in;
            y_next    = '0;
            z_next    = z_in;
        end else if (busy_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

>>> hw/rtl/differential_drive_odometry_core.sv
// top level of the differential drive odometry core: sequencer, shared multiplier, pose state
// depends on ddo_pkg, ddo_div and ddo_cordic
`timescale 1ns / 1ps

// Each item carries absolute left and right encoder counts and the microseconds since the
// previous item. The first item after reset only stores the counts, and an item with zero
// elapsed time is dropped; neither gives a result. Every other item gives one result: pose
// (x, y in Q16.16 m, heading as a 32-bit binary angle), wheel and body speeds, turn rate and
// both wheel joint angles. Work is done by a small sequencer around one 32x32 multiplier,
// one bit-per-cycle divider and one cordic unit. An item runs four divisions, for the two
// wheel speeds, the turn rate and the heading step, one cordic rotation and the multiplies
// and sequencing around them. s_ready is high only between items. A finished result sits
// in an output register, so the next item may be taken while it waits; only a second
// result waiting on the first holds the sequencer in its last state.
// Configuration registers may be written at any time the block is idle.

module differential_drive_odometry_core #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_left_count,
    input  logic signed [31:0] s_right_count,
    input  logic        [23:0] s_elapsed_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic        [31:0] m_heading,
    output logic signed [31:0] m_forward_speed,
    output logic signed [31:0] m_turn_rate,
    output logic signed [31:0] m_left_speed,
    output logic signed [31:0] m_right_speed,
    output logic signed [47:0] m_left_angle,
    output logic signed [47:0] m_right_angle,
    input  logic               cfg_we,
    input  logic        [1:0]  cfg_index,
    input  logic        [31:0] cfg_data
);
    import ddo_pkg::*;

    seq_state_t state_reg, state_next;

    // configuration
    logic [31:0] mpc_reg, apc_reg;
    logic [20:0] tw_reg;

    // persistent odometry state
    logic [31:0]        prev_l_reg, prev_r_reg;
    logic               primed_reg;
    logic signed [47:0] acc_x_reg, acc_y_reg;
    logic [31:0]        head_reg;

    // per-item working registers
    logic [31:0]        lc_reg, rc_reg;
    logic [23:0]        us_reg;
    logic [31:0]        dl_reg, dr_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_lo_reg;
    logic [63:0]        plmag_reg, prmag_reg;
    logic signed [63:0] pl_reg, pr_reg;
    logic [31:0]        sl_reg, sr_reg, tr_reg;
    logic [48:0]        d16mag_reg;
    logic               d16neg_reg;
    logic [31:0]        hstep_reg;
    logic [47:0]        dsmag_reg;
    logic               dsneg_reg;
    logic [47:0]        la_reg, ra_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] o_x_reg, o_y_reg, o_head_reg, o_fwd_reg, o_tr_reg, o_sl_reg, o_sr_reg;
    logic [47:0] o_la_reg, o_ra_reg;

    // control from the sequencer
    logic accept, work, div_start, cord_start, out_load;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // divider and cordic hookup
    logic [DIV_W-1:0]         div_dividend, div_q;
    logic [DVS_W-1:0]         div_divisor;
    logic                     div_done;
    logic signed [CORD_W-1:0] cord_x0, cord_x, cord_y, x_base;
    logic signed [ANG_W-1:0]  cord_z0, hz;
    logic                     cord_done;

    // misc datapath
    logic [95:0]        wide_sum;
    logic [DVS_W-1:0]   tw_eff;
    logic signed [32:0] tdiff;
    logic [32:0]        trmag;
    logic signed [48:0] d16;
    logic signed [63:0] ds;
    logic [63:0]        kin_sum;
    logic [47:0]        kin_m;
    logic               fold_hi, fold_lo;
    logic signed [50:0] sum_x, sum_y;
    logic signed [32:0] fsum, fsum_adj;
    logic signed [63:0] ang_s;

    assign accept = s_valid && s_ready;
    // an item that does real work: primed and with time gone by
    assign work   = accept && primed_reg && (s_elapsed_us != 24'd0);

    assign tw_eff = (tw_reg == 21'd0) ? DVS_W'(1) : {3'b000, tw_reg};

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        cord_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (work) begin
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_SPD_L0;
            ST_SPD_L0: state_next = ST_SPD_L1;
            ST_SPD_L1: state_next = ST_SPD_L2;
            ST_SPD_L2: begin
                div_start  = 1'b1;
                state_next = ST_SPD_LW;
            end
            ST_SPD_LW: if (div_done) begin
                state_next = ST_SPD_R0;
            end
            ST_SPD_R0: state_next = ST_SPD_R1;
            ST_SPD_R1: state_next = ST_SPD_R2;
            ST_SPD_R2: begin
                div_start  = 1'b1;
                state_next = ST_SPD_RW;
            end
            ST_SPD_RW: if (div_done) begin
                state_next = ST_TURN;
            end
            ST_TURN: begin
                div_start  = 1'b1;
                state_next = ST_TURN_W;
            end
            ST_TURN_W: if (div_done) begin
                state_next = ST_HEAD0;
            end
            ST_HEAD0: state_next = ST_HEAD1;
            ST_HEAD1: state_next = ST_HEAD2;
            ST_HEAD2: state_next = ST_HEAD3;
            ST_HEAD3: begin
                div_start  = 1'b1;
                state_next = ST_HEAD_W;
            end
            ST_HEAD_W: if (div_done) begin
                state_next = ST_DIST0;
            end
            ST_DIST0: state_next = ST_DIST1;
            ST_DIST1: state_next = ST_DIST2;
            ST_DIST2: state_next = ST_DIST3;
            ST_DIST3: begin
                cord_start = 1'b1;
                state_next = ST_CORD_W;
            end
            ST_CORD_W: if (cord_done) begin
                state_next = ST_ANG_L;
            end
            ST_ANG_L:   state_next = ST_ANG_R;
            ST_ANG_R:   state_next = ST_ANG_FIN;
            ST_ANG_FIN: state_next = ST_PUB;
            ST_PUB: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_L: begin
                mul_a = abs32(dl_reg);
                mul_b = mpc_reg;
            end
            ST_MUL_R: begin
                mul_a = abs32(dr_reg);
                mul_b = mpc_reg;
            end
            ST_SPD_L0: begin
                mul_a = plmag_reg[31:0];
                mul_b = US_PER_S;
            end
            ST_SPD_L1: begin
                mul_a = plmag_reg[63:32];
                mul_b = US_PER_S;
            end
            ST_SPD_R0: begin
                mul_a = prmag_reg[31:0];
                mul_b = US_PER_S;
            end
            ST_SPD_R1: begin
                mul_a = prmag_reg[63:32];
                mul_b = US_PER_S;
            end
            ST_HEAD1: begin
                mul_a = d16mag_reg[31:0];
                mul_b = RAD_TO_BIN;
            end
            ST_HEAD2: begin
                mul_a = {15'd0, d16mag_reg[48:32]};
                mul_b = RAD_TO_BIN;
            end
            ST_DIST1: begin
                mul_a = dsmag_reg[47:16];
                mul_b = KINV_Q32;
            end
            ST_DIST2: begin
                mul_a = {16'd0, dsmag_reg[15:0]};
                mul_b = KINV_Q32;
            end
            ST_ANG_L: begin
                mul_a = abs32(lc_reg);
                mul_b = apc_reg;
            end
            ST_ANG_R: begin
                mul_a = abs32(rc_reg);
                mul_b = apc_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // two-part product reassembled: high half shifted up by 32
    assign wide_sum = {prod_reg, 32'd0} + {32'd0, acc_lo_reg};

    // turn rate numerator
    assign tdiff = {sr_reg[31], sr_reg} - {sl_reg[31], sl_reg};
    assign trmag = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);

    // divider operands
    always_comb begin
        div_dividend = '0;
        div_divisor  = tw_eff;
        unique case (state_reg)
            ST_SPD_L2, ST_SPD_R2: begin
                div_dividend = {12'd0, wide_sum[83:16]};
                div_divisor  = us_reg;
            end
            ST_TURN: begin
                div_dividend = {31'd0, trmag, 16'd0};
            end
            ST_HEAD3: begin
                div_dividend = wide_sum[79:0];
            end
            default: begin
                div_dividend = '0;
            end
        endcase
    end

    ddo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // heading step numerator and distance step
    assign d16 = 49'(pr_reg >>> 16) - 49'(pl_reg >>> 16);
    assign ds  = (pl_reg >>> 1) + (pr_reg >>> 1);

    // pre-scale by the inverse cordic gain
    assign kin_sum = acc_lo_reg + {16'd0, prod_reg[63:16]};
    assign kin_m   = kin_sum[63:16];
    assign x_base  = dsneg_reg ? -$signed({2'b00, kin_m}) : $signed({2'b00, kin_m});

    // fold heading into a quarter turn by a half-turn rotation
    assign hz      = ANG_W'($signed(head_reg));
    assign fold_hi = hz > 34'sd1073741824;
    assign fold_lo = hz < -34'sd1073741824;
    always_comb begin
        cord_z0 = hz;
        cord_x0 = x_base;
        if (fold_hi) begin
            cord_z0 = hz - 34'sd2147483648;
            cord_x0 = -x_base;
        end else if (fold_lo) begin
            cord_z0 = hz + 34'sd2147483648;
            cord_x0 = -x_base;
        end
    end

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .x_in    (cord_x0),
        .z_in    (cord_z0),
        .done    (cord_done),
        .x_out   (cord_x),
        .y_out   (cord_y)
    );

    assign sum_x = 51'(acc_x_reg) + 51'(cord_x);
    assign sum_y = 51'(acc_y_reg) + 51'(cord_y);

    // mean speed, truncated toward zero
    assign fsum     = $signed({sl_reg[31], sl_reg}) + $signed({sr_reg[31], sr_reg});
    assign fsum_adj = fsum + $signed({32'd0, fsum[32]});

    // joint angle from the current product
    always_comb begin
        ang_s = $signed(prod_reg);
        if (state_reg == ST_ANG_R) begin
            if (lc_reg[31]) begin
                ang_s = -$signed(prod_reg);
            end
        end else if (rc_reg[31]) begin
            ang_s = -$signed(prod_reg);
        end
    end

    // control and persistent state
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mpc_reg     <= MPC_RESET;
            apc_reg     <= APC_RESET;
            tw_reg      <= TW_RESET;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            primed_reg  <= 1'b0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MPC: mpc_reg <= cfg_data;
                    CFG_APC: apc_reg <= cfg_data;
                    CFG_TW:  tw_reg  <= cfg_data[20:0];
                    default: ;
                endcase
            end
            // first item only primes the stored counts
            if (accept && !primed_reg) begin
                prev_l_reg <= s_left_count;
                prev_r_reg <= s_right_count;
                primed_reg <= 1'b1;
            end else if (work) begin
                prev_l_reg <= s_left_count;
                prev_r_reg <= s_right_count;
            end
            if (state_reg == ST_CORD_W && cord_done) begin
                if (sum_x > 51'sd140737488355327) begin
                    acc_x_reg <= 48'sh7FFF_FFFF_FFFF;
                end else if (sum_x < -51'sd140737488355328) begin
                    acc_x_reg <= 48'sh8000_0000_0000;
                end else begin
                    acc_x_reg <= sum_x[47:0];
                end
                if (sum_y > 51'sd140737488355327) begin
                    acc_y_reg <= 48'sh7FFF_FFFF_FFFF;
                end else if (sum_y < -51'sd140737488355328) begin
                    acc_y_reg <= 48'sh8000_0000_0000;
                end else begin
                    acc_y_reg <= sum_y[47:0];
                end
                head_reg <= head_reg + hstep_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (work) begin
            lc_reg <= s_left_count;
            rc_reg <= s_right_count;
            us_reg <= s_elapsed_us;
            dl_reg <= s_left_count - prev_l_reg;
            dr_reg <= s_right_count - prev_r_reg;
        end
        unique case (state_reg)
            ST_MUL_R: begin
                plmag_reg <= prod_reg;
                pl_reg    <= dl_reg[31] ? -$signed(prod_reg) : $signed(prod_reg);
            end
            ST_SPD_L0: begin
                prmag_reg <= prod_reg;
                pr_reg    <= dr_reg[31] ? -$signed(prod_reg) : $signed(prod_reg);
            end
            ST_SPD_L1, ST_SPD_R1, ST_HEAD2, ST_DIST2: begin
                acc_lo_reg <= prod_reg;
            end
            ST_SPD_LW: if (div_done) begin
                sl_reg <= sat_quot(div_q, dl_reg[31]);
            end
            ST_SPD_RW: if (div_done) begin
                sr_reg <= sat_quot(div_q, dr_reg[31]);
            end
            ST_TURN_W: if (div_done) begin
                tr_reg <= sat_quot(div_q, tdiff[32]);
            end
            ST_HEAD0: begin
                d16neg_reg <= d16[48];
                d16mag_reg <= d16[48] ? 49'(-d16) : 49'(d16);
            end
            ST_HEAD_W: if (div_done) begin
                hstep_reg <= d16neg_reg ? (~div_q[31:0] + 32'd1) : div_q[31:0];
            end
            ST_DIST0: begin
                // clamp to the 48-bit range before taking the magnitude
                if (ds > 64'sd140737488355327) begin
                    dsneg_reg <= 1'b0;
                    dsmag_reg <= 48'h7FFF_FFFF_FFFF;
                end else if (ds < -64'sd140737488355328) begin
                    dsneg_reg <= 1'b1;
                    dsmag_reg <= 48'h8000_0000_0000;
                end else begin
                    dsneg_reg <= ds[63];
                    dsmag_reg <= ds[63] ? 48'(-ds) : 48'(ds);
                end
            end
            ST_ANG_R: begin
                la_reg <= ang_s[63:16];
            end
            ST_ANG_FIN: begin
                ra_reg <= ang_s[63:16];
            end
            default: ;
        endcase
        if (out_load) begin
            o_x_reg    <= acc_x_reg[47:16];
            o_y_reg    <= acc_y_reg[47:16];
            o_head_reg <= head_reg;
            o_fwd_reg  <= fsum_adj[32:1];
            o_tr_reg   <= tr_reg;
            o_sl_reg   <= sl_reg;
            o_sr_reg   <= sr_reg;
            o_la_reg   <= la_reg;
            o_ra_reg   <= ra_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = o_x_reg;
    assign m_pos_y         = o_y_reg;
    assign m_heading       = o_head_reg;
    assign m_forward_speed = o_fwd_reg;
    assign m_turn_rate     = o_tr_reg;
    assign m_left_speed    = o_sl_reg;
    assign m_right_speed   = o_sr_reg;
    assign m_left_angle    = o_la_reg;
    assign m_right_angle   = o_ra_reg;

endmodule

>>> hw/rtl/ddo_checker.sv
// port-level checks for the odometry core, attached by bind
// depends on differential_drive_odometry_core
`timescale 1ns / 1ps

module ddo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [31:0] s_left_count,
    input logic signed [31:0] s_right_count,
    input logic        [23:0] s_elapsed_us,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pos_x,
    input logic signed [31:0] m_pos_y,
    input logic        [31:0] m_heading,
    input logic signed [31:0] m_forward_speed,
    input logic signed [31:0] m_turn_rate,
    input logic signed [31:0] m_left_speed,
    input logic signed [31:0] m_right_speed,
    input logic signed [47:0] m_left_angle,
    input logic signed [47:0] m_right_angle,
    input logic               cfg_we,
    input logic        [1:0]  cfg_index,
    input logic        [31:0] cfg_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result stays valid and its x position, heading and left angle hold
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_heading)
            && $stable(m_left_angle))
        else $error("stalled result changed");

    // a result never appears the cycle after an item is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    // a new result is only published from the busy sequencer
    a_pub_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result published while idle");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);

>>> test/differential_drive_odometry_core_tb.sv
// testbench for differential_drive_odometry_core: directed and random encoder items
// depends on ddo_pkg and the core rtl; self-checking against an own pose predictor
`timescale 1ns / 1ps

module differential_drive_odometry_core_tb;
    import ddo_pkg::*;

    // one result item of the block
    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] forward_speed;
        logic [31:0] turn_rate;
        logic [31:0] left_speed;
        logic [31:0] right_speed;
        logic [47:0] left_angle;
        logic [47:0] right_angle;
    } odo_result_t;

    // pose predictor plus queue of pending results
    class odometry_scoreboard;
        logic [31:0] mpc = MPC_RESET;
        logic [31:0] apc = APC_RESET;
        logic [20:0] tw  = TW_RESET;
        logic [31:0] last_left = 0, last_right = 0, yaw = 0;
        bit          primed = 0;
        longint      pose_x = 0, pose_y = 0;
        odo_result_t pending[$];
        int          errors = 0;

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint sat48(longint v);
            longint lim;
            lim = 64'sd1 <<< 47;
            if (v > lim - 1) return lim - 1;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // wheel speed in Q16.16 m/s from travel in 2^-32 m
        function longint wheel_speed(longint p, logic [23:0] us);
            logic [127:0] num, quo;
            logic [63:0]  a;
            a = p < 0 ? 64'(-p) : 64'(p);
            num = 128'(a) * 128'd1000000;
            quo = num / {88'd0, us, 16'd0};
            if (quo > 128'h8000_0000) return p < 0 ? -64'sd2147483648 : 64'sd2147483647;
            return sat32(p < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]));
        endfunction

        function void note_item(logic [31:0] lc, logic [31:0] rc, logic [23:0] us);
            longint dl, dr, pl, pr, sl, sr, tr, ds, d16, x, y, z, xs, ys, twv;
            logic [63:0]  m;
            logic [127:0] prod;
            logic [31:0]  step;
            odo_result_t  r;
            if (!primed) begin
                last_left = lc;
                last_right = rc;
                primed = 1;
                return;
            end
            if (us == 0) return;   // zero elapsed time: dropped
            dl = longint'(signed'(lc - last_left));
            dr = longint'(signed'(rc - last_right));
            last_left = lc;
            last_right = rc;
            pl = dl * longint'({32'd0, mpc});
            pr = dr * longint'({32'd0, mpc});
            twv = (tw == 0) ? 1 : longint'({43'd0, tw});
            sl = wheel_speed(pl, us);
            sr = wheel_speed(pr, us);
            tr = sat32(((sr - sl) * 65536) / twv);

            // distance step, prescaled, rotated by old heading
            ds = (pl >>> 1) + (pr >>> 1);
            if (ds > (64'sd1 <<< 47) - 1) ds = (64'sd1 <<< 47) - 1;
            if (ds < -(64'sd1 <<< 47)) ds = -(64'sd1 <<< 47);
            m = ds < 0 ? 64'(-ds) : 64'(ds);
            m = ((m >> 16) * 64'(KINV_Q32) + (((m & 64'hFFFF) * 64'(KINV_Q32)) >> 16)) >> 16;
            x = ds < 0 ? -longint'(m) : longint'(m);
            y = 0;
            z = longint'(signed'(yaw));
            if (z > (64'sd1 <<< 30)) begin
                z -= 64'sd1 <<< 31;
                x = -x;
            end else if (z < -(64'sd1 <<< 30)) begin
                z += 64'sd1 <<< 31;
                x = -x;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= longint'({32'd0, atan_bin(5'(i))});
                end else begin
                    x += ys;
                    y -= xs;
                    z += longint'({32'd0, atan_bin(5'(i))});
                end
            end
            pose_x = sat48(pose_x + x);
            pose_y = sat48(pose_y + y);

            // heading step, modulo a full turn
            d16 = (pr >>> 16) - (pl >>> 16);
            prod = 128'(d16 < 0 ? 64'(-d16) : 64'(d16)) * 128'(RAD_TO_BIN);
            prod = prod / 128'(twv);
            step = prod[31:0];
            if (d16 < 0) step = -step;
            yaw = yaw + step;

            r.pos_x = 32'(pose_x >>> 16);
            r.pos_y = 32'(pose_y >>> 16);
            r.heading = yaw;
            r.forward_speed = 32'((sl + sr) / 2);
            r.turn_rate = 32'(tr);
            r.left_speed = 32'(sl);
            r.right_speed = 32'(sr);
            r.left_angle = 48'((longint'(signed'(lc)) * longint'({32'd0, apc})) >>> 16);
            r.right_angle = 48'((longint'(signed'(rc)) * longint'({32'd0, apc})) >>> 16);
            pending.push_back(r);
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(odo_result_t got);
            odo_result_t w;
            if (pending.size() == 0) begin
                report("unexpected item", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.pos_x != w.pos_x) report("pos_x", got.pos_x, w.pos_x);
            if (got.pos_y != w.pos_y) report("pos_y", got.pos_y, w.pos_y);
            if (got.heading != w.heading) report("heading", got.heading, w.heading);
            if (got.forward_speed != w.forward_speed)
                report("forward_speed", got.forward_speed, w.forward_speed);
            if (got.turn_rate != w.turn_rate) report("turn_rate", got.turn_rate, w.turn_rate);
            if (got.left_speed != w.left_speed) report("left_speed", got.left_speed, w.left_speed);
            if (got.right_speed != w.right_speed)
                report("right_speed", got.right_speed, w.right_speed);
            if (got.left_angle != w.left_angle) report("left_angle", got.left_angle, w.left_angle);
            if (got.right_angle != w.right_angle)
                report("right_angle", got.right_angle, w.right_angle);
        endtask
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_left_count = 0;
    logic signed [31:0] s_right_count = 0;
    logic        [23:0] s_elapsed_us = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_pos_x, m_pos_y, m_forward_speed, m_turn_rate;
    logic signed [31:0] m_left_speed, m_right_speed;
    logic        [31:0] m_heading;
    logic signed [47:0] m_left_angle, m_right_angle;
    logic               cfg_we = 0;
    logic        [1:0]  cfg_index = CFG_MPC;
    logic        [31:0] cfg_data = 0;

    odometry_scoreboard sb = new();

    // encoder positions the random walk starts from
    logic [31:0] enc_left = 0, enc_right = 0;
    int          burst_left = 0;

    differential_drive_odometry_core dut (.*);

    // 4 ns clock
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // receiver: long ready stretches, then spells of random stalls
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (stall_phase == 0) begin
            stall_phase <= $urandom_range(50, 600);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        if (stall_phase > 300) begin
            m_ready <= 1'b1;
        end else if (stall_phase > 150) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= ($urandom_range(0, 7) == 0);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        odo_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pos_x = m_pos_x;
            got.pos_y = m_pos_y;
            got.heading = m_heading;
            got.forward_speed = m_forward_speed;
            got.turn_rate = m_turn_rate;
            got.left_speed = m_left_speed;
            got.right_speed = m_right_speed;
            got.left_angle = m_left_angle;
            got.right_angle = m_right_angle;
            sb.check_result(got);
        end
    end

    // send one item; bursts of back-to-back items with random gaps between
    task send_item(logic [31:0] lc, logic [31:0] rc, logic [23:0] us);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_left_count <= lc;
        s_right_count <= rc;
        s_elapsed_us <= us;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(lc, rc, us);
        burst_left--;
        enc_left = lc;
        enc_right = rc;
    endtask

    // wait out outstanding results plus any dropped item still in flight
    task drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    // one register write; the enable is dropped by set_config after the last one
    task write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_MPC: sb.mpc = val;
            CFG_APC: sb.apc = val;
            default: sb.tw = val[20:0];
        endcase
    endtask

    task set_config(logic [31:0] mpc, logic [31:0] apc, logic [31:0] tw);
        write_reg(CFG_MPC, mpc);
        write_reg(CFG_APC, apc);
        write_reg(CFG_TW, tw);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // random item: mostly realistic wheel motion, some wild jumps and dropped items
    task random_items(int n);
        logic [31:0] dl, dr;
        logic [23:0] us;
        int          kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                dl = $urandom_range(0, 4000) - 2000;
                dr = (kind < 20) ? dl + $urandom_range(0, 200) - 100
                                 : $urandom_range(0, 4000) - 2000;
                us = 24'($urandom_range(20000, 50000));
            end else if (kind < 80) begin
                dl = $urandom_range(0, 2000000) - 1000000;
                dr = $urandom_range(0, 2000000) - 1000000;
                us = 24'($urandom_range(1, 24'hFFFFFF));
            end else if (kind < 95) begin
                dl = $urandom;
                dr = $urandom;
                us = (kind < 90) ? 24'($urandom) : 24'($urandom_range(1, 16));
            end else begin
                dl = $urandom_range(0, 100);
                dr = $urandom_range(0, 100);
                us = 24'd0;
            end
            send_item(enc_left + dl, enc_right + dr, us);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first item only primes, even with zero elapsed time
        send_item(32'h7FFF_FFF0, 32'h8000_0010, 24'd0);
        send_item(32'h7FFF_FFF0, 32'h8000_0010, 24'd0);        // ignored
        send_item(32'h8000_0010, 32'h7FFF_FFF0, 24'd1);        // wrap across limits
        send_item(32'h0000_0000, 32'h0000_0000, 24'hFFFFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 24'd1);        // largest deltas
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd33333);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 24'd5);        // no motion
        for (int k = 0; k < 8; k++)                            // spin round the heading
            send_item(enc_left - 32'd40000, enc_right + 32'd40000, 24'd30000);
        for (int k = 0; k < 4; k++)                            // drive straight
            send_item(enc_left + 32'd3000, enc_right + 32'd3000, 24'd30000);
        send_item(enc_left + 32'd5, enc_right - 32'd5, 24'd0); // ignored
        random_items(230);
        drain();

        set_config(32'd1, 32'd1, 32'd1);
        random_items(170);
        drain();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1048576);
        random_items(170);
        drain();
        set_config($urandom, $urandom, 32'd0);                 // zero track width acts as one
        random_items(170);
        drain();
        set_config($urandom_range(1, 4000000), $urandom, 32'h001F_FFFF);
        random_items(170);
        drain();
        set_config(MPC_RESET, APC_RESET, $urandom_range(1, 1048576));
        random_items(170);
        drain();

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> differential_drive_odometry_core.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_div.sv
hw/rtl/ddo_cordic.sv
hw/rtl/differential_drive_odometry_core.sv
hw/rtl/ddo_checker.sv
test/differential_drive_odometry_core_tb.sv
